// ===== src/pfe_pkg.sv =====
package pfe_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DIV_CNT_W   = $clog2(VALUE_WIDTH);

  localparam logic [7:0] SYM_MUL  = 8'd42;
  localparam logic [7:0] SYM_ADD  = 8'd43;
  localparam logic [7:0] SYM_SUB  = 8'd45;
  localparam logic [7:0] SYM_DIV  = 8'd47;
  localparam logic [7:0] SYM_ZERO = 8'd48;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_code_t;

  typedef logic [VALUE_WIDTH-1:0] value_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_EXEC,
    S_DIV_WAIT,
    S_WRITE,
    S_SETTLE,
    S_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic         load;
    logic         push;
    logic         set_err;
    status_code_t err_code;
    logic         div_start;
    logic         cap_alu;
    logic         cap_div;
    logic         write_res;
    logic         emit;
  } dp_cmd_t;

  typedef struct packed {
    logic err_set;
    logic is_op;
    logic op_div;
    logic full;
    logic under;
    logic rhs_zero;
    logic div_done;
    logic out_busy;
    logic is_last;
  } dp_status_t;

  function automatic logic is_operator(input logic [7:0] sym);
    return (sym == SYM_MUL) || (sym == SYM_DIV) || (sym == SYM_ADD) || (sym == SYM_SUB);
  endfunction

  // An operand is its character code less that of the digit zero, taken as signed.
  function automatic value_t operand_value(input logic [7:0] sym);
    logic signed [8:0]  diff;
    logic signed [63:0] wide;
    diff = $signed({1'b0, sym}) - $signed({1'b0, SYM_ZERO});
    wide = 64'(diff);
    return value_t'(wide);
  endfunction

  function automatic logic signed [31:0] to_result(input value_t v);
    logic signed [63:0] ext;
    ext = 64'(signed'(v));
    return ext[31:0];
  endfunction

endpackage

// ===== src/pfe_divider.sv =====
module pfe_divider (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  pfe_pkg::value_t dividend,
  input  pfe_pkg::value_t divisor,
  output logic            done,
  output pfe_pkg::value_t quotient
);
  import pfe_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 neg_r;
  value_t               quot_r;
  value_t               rem_r;
  value_t               dvs_r;

  logic                 a_neg;
  logic                 b_neg;
  value_t               mag_a;
  value_t               mag_b;
  logic [VALUE_WIDTH:0] shifted;
  logic [VALUE_WIDTH:0] diff;
  logic                 take;

  assign a_neg = dividend[VALUE_WIDTH-1];
  assign b_neg = divisor[VALUE_WIDTH-1];
  assign mag_a = a_neg ? -dividend : dividend;
  assign mag_b = b_neg ? -divisor : divisor;

  // One restoring step per cycle on the magnitudes, most significant bit first.
  assign shifted = {rem_r, quot_r[VALUE_WIDTH-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign take    = !diff[VALUE_WIDTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(VALUE_WIDTH - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= mag_a;
      rem_r  <= '0;
      dvs_r  <= mag_b;
      neg_r  <= a_neg ^ b_neg;
    end else if (busy_r) begin
      quot_r <= {quot_r[VALUE_WIDTH-2:0], take};
      rem_r  <= take ? diff[VALUE_WIDTH-1:0] : shifted[VALUE_WIDTH-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -quot_r : quot_r;

endmodule

// ===== src/pfe_dpath.sv =====
module pfe_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  pfe_pkg::in_item_t   in_data,
  input  pfe_pkg::dp_cmd_t    cmd,
  output pfe_pkg::dp_status_t stat,
  input  logic                out_stall,
  output logic                out_valid,
  output pfe_pkg::out_item_t  out_data
);
  import pfe_pkg::*;

  logic [7:0]       sym_r;
  logic             last_r;
  logic [CNT_W-1:0] count_r;
  status_code_t     err_r;
  value_t           stack_mem [STACK_DEPTH];
  value_t           top_r;
  value_t           below_r;
  value_t           res_r;
  logic             out_valid_r;
  out_item_t        out_data_r;

  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  cnt_m2;
  logic [ADDR_W-1:0] top_addr;
  logic [ADDR_W-1:0] below_addr;
  logic [ADDR_W-1:0] push_addr;
  value_t            alu;
  value_t            div_q;
  logic              div_done;
  out_item_t         emit_item;

  assign cnt_m1     = count_r - CNT_W'(1);
  assign cnt_m2     = count_r - CNT_W'(2);
  assign top_addr   = cnt_m1[ADDR_W-1:0];
  assign below_addr = cnt_m2[ADDR_W-1:0];
  assign push_addr  = count_r[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sym_r  <= in_data.symbol;
      last_r <= in_data.is_last;
    end
  end

  // The two read ports follow the stack pointer every cycle.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack_mem[push_addr] <= operand_value(sym_r);
    end else if (cmd.write_res) begin
      stack_mem[below_addr] <= res_r;
    end
    top_r   <= stack_mem[top_addr];
    below_r <= stack_mem[below_addr];
  end

  pfe_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (below_r),
    .divisor  (top_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    unique case (sym_r)
      SYM_MUL: alu = below_r * top_r;
      SYM_SUB: alu = below_r - top_r;
      default: alu = below_r + top_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_alu) begin
      res_r <= alu;
    end else if (cmd.cap_div) begin
      res_r <= div_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      err_r   <= ST_OK;
    end else if (cmd.emit) begin
      count_r <= '0;
      err_r   <= ST_OK;
    end else begin
      if (cmd.push) begin
        count_r <= count_r + CNT_W'(1);
      end else if (cmd.write_res) begin
        count_r <= cnt_m1;
      end
      if (cmd.set_err) begin
        err_r <= cmd.err_code;
      end
    end
  end

  always_comb begin
    emit_item.result_value = '0;
    emit_item.status       = err_r;
    if (err_r == ST_OK) begin
      if (count_r != '0) begin
        emit_item.result_value = to_result(top_r);
      end else begin
        emit_item.status = ST_UNDER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= emit_item;
    end
  end

  assign stat.err_set  = (err_r != ST_OK);
  assign stat.is_op    = is_operator(sym_r);
  assign stat.op_div   = (sym_r == SYM_DIV);
  assign stat.full     = (count_r >= CNT_W'(STACK_DEPTH));
  assign stat.under    = (count_r < CNT_W'(2));
  assign stat.rhs_zero = (top_r == '0);
  assign stat.div_done = div_done;
  assign stat.out_busy = out_valid_r && out_stall;
  assign stat.is_last  = last_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> count_r < CNT_W'(STACK_DEPTH))
    else $error("push onto a full stack");

  a_pop_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write_res |-> count_r >= CNT_W'(2))
    else $error("result written with fewer than two entries");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (count_r == '0 && err_r == ST_OK && out_valid_r))
    else $error("state not cleared after a result");

endmodule

// ===== src/pfe_ctrl.sv =====
module pfe_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pfe_pkg::dp_status_t stat,
  output pfe_pkg::dp_cmd_t    cmd
);
  import pfe_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;
  ctrl_state_t done_state;

  // After an item, the last character of an expression goes on to read the top.
  assign done_state = stat.is_last ? S_SETTLE : S_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.err_set || !stat.is_op || stat.under) begin
          state_nxt = done_state;
        end else begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!stat.op_div) begin
          state_nxt = S_WRITE;
        end else if (stat.rhs_zero) begin
          state_nxt = done_state;
        end else begin
          state_nxt = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (stat.div_done) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE:  state_nxt = done_state;
      S_SETTLE: state_nxt = S_EMIT;
      S_EMIT: begin
        if (!stat.out_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.err_code = ST_OK;
    in_stall     = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_DECODE: begin
        if (!stat.err_set) begin
          if (!stat.is_op) begin
            if (stat.full) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = ST_OVER;
            end else begin
              cmd.push = 1'b1;
            end
          end else if (stat.under) begin
            cmd.set_err  = 1'b1;
            cmd.err_code = ST_UNDER;
          end
        end
      end
      S_EXEC: begin
        if (!stat.op_div) begin
          cmd.cap_alu = 1'b1;
        end else if (stat.rhs_zero) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_DIVZ;
        end else begin
          cmd.div_start = 1'b1;
        end
      end
      S_DIV_WAIT: cmd.cap_div   = stat.div_done;
      S_WRITE:    cmd.write_res = 1'b1;
      S_SETTLE:   cmd.load      = 1'b0;
      S_EMIT:     cmd.emit      = !stat.out_busy;
      default:    cmd.load      = 1'b0;
    endcase
  end

endmodule

// ===== src/postfix_expression_evaluator.sv =====
// Channel  Direction  Ports                                Payload
// input    in         in_valid, in_stall, in_data          symbol, is_last
// result   out        out_valid, out_stall, out_data       result_value, status
//
// An operand passes through states IDLE and DECODE, an add, subtract or multiply
// through IDLE, DECODE, EXEC and WRITE, and a divide also waits in DIV_WAIT on the
// one-bit-per-cycle divider. The last character of an expression then passes through
// SETTLE, to read the top of the stack, and EMIT, to load the output register.
// Reset is synchronous and active low; it empties the stack and clears the error.
// A new transaction is taken while a finished result still waits at the output.
module postfix_expression_evaluator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pfe_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pfe_pkg::out_item_t out_data
);
  import pfe_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t stat;

  pfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  pfe_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== tb/tb_postfix_expression_evaluator.sv =====
module tb_postfix_expression_evaluator;
  import pfe_pkg::*;

  localparam int ITEM_TARGET = 1150;
  localparam int CALM_TAIL   = 100;
  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 60;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } plan_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  logic      calm = 1'b0;
  int        stall_run = 0;
  int        cycle_count = 0;
  int        error_count = 0;
  int        live_items = 0;
  int        expressions = 0;
  int        results_checked = 0;
  int        status_seen [4];

  // Expected results, oldest first.
  out_item_t pending_results [$];

  // Evaluation state mirrored from the block.
  value_t       eval_stack [STACK_DEPTH];
  int           eval_depth = 0;
  status_code_t eval_err = ST_OK;

  postfix_expression_evaluator u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] ERROR %s", $time, msg);
    error_count++;
  endtask

  function automatic logic [7:0] digit(input int n);
    return SYM_ZERO + 8'(n);
  endfunction

  function automatic bit is_arith(input logic [7:0] sym);
    return sym == SYM_MUL || sym == SYM_DIV || sym == SYM_ADD || sym == SYM_SUB;
  endfunction

  function automatic plan_row_t plan_step(input logic [7:0] sym, input bit last,
                                          input bit typed, input int val,
                                          input status_code_t st);
    plan_row_t r;
    r.item.symbol        = sym;
    r.item.is_last       = last;
    r.typed              = typed;
    r.want.result_value  = val;
    r.want.status        = st;
    return r;
  endfunction

  // Applies one character to the mirrored stack; returns 1 when a result is due.
  function automatic bit evaluate_symbol(input in_item_t it, output out_item_t res);
    value_t lhs, rhs, mag_l, mag_r, outcome;
    int     operand;
    if (eval_err == ST_OK) begin
      live_items++;
      if (!is_arith(it.symbol)) begin
        if (eval_depth >= STACK_DEPTH) begin
          eval_err = ST_OVER;
        end else begin
          operand = int'(it.symbol) - int'(SYM_ZERO);
          eval_stack[eval_depth] = value_t'(operand);
          eval_depth++;
        end
      end else if (eval_depth < 2) begin
        eval_err = ST_UNDER;
      end else begin
        rhs = eval_stack[eval_depth-1];
        lhs = eval_stack[eval_depth-2];
        outcome = '0;
        if (it.symbol == SYM_DIV && rhs == '0) begin
          eval_err = ST_DIVZ;
        end else begin
          case (it.symbol)
            SYM_MUL: outcome = lhs * rhs;
            SYM_ADD: outcome = lhs + rhs;
            SYM_SUB: outcome = lhs - rhs;
            default: begin
              // Divide on magnitudes so that truncation is towards zero.
              mag_l = lhs[VALUE_WIDTH-1] ? -lhs : lhs;
              mag_r = rhs[VALUE_WIDTH-1] ? -rhs : rhs;
              outcome = mag_l / mag_r;
              if (lhs[VALUE_WIDTH-1] != rhs[VALUE_WIDTH-1]) outcome = -outcome;
            end
          endcase
          eval_depth--;
          eval_stack[eval_depth-1] = outcome;
        end
      end
    end
    res = '0;
    if (!it.is_last) return 1'b0;
    res.status = eval_err;
    if (eval_err == ST_OK) begin
      if (eval_depth >= 1) res.result_value = 32'($signed(eval_stack[eval_depth-1]));
      else res.status = ST_UNDER;
    end
    eval_depth = 0;
    eval_err = ST_OK;
    expressions++;
    return 1'b1;
  endfunction

  task automatic feed_symbol(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t predicted;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    if (evaluate_symbol(it, predicted)) pending_results.push_back(typed ? want : predicted);
  endtask

  // Holds the input idle until every outstanding result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic feed_expression(input logic [7:0] syms [$]);
    in_item_t it;
    for (int i = 0; i < syms.size(); i++) begin
      it.symbol  = syms[i];
      it.is_last = (i == syms.size() - 1);
      feed_symbol(it, 1'b0, '0);
    end
  endtask

  function automatic logic [7:0] random_operand();
    logic [7:0] s;
    if ($urandom_range(0, 1) == 0) return digit($urandom_range(0, 9));
    do s = 8'($urandom_range(0, 255)); while (is_arith(s));
    return s;
  endfunction

  function automatic logic [7:0] random_operator();
    case ($urandom_range(0, 3))
      0:       return SYM_MUL;
      1:       return SYM_DIV;
      2:       return SYM_ADD;
      default: return SYM_SUB;
    endcase
  endfunction

  task automatic build_well_formed(output logic [7:0] syms [$]);
    int left, depth;
    syms  = {};
    left  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, STACK_DEPTH)
                                        : $urandom_range(1, 6);
    depth = 0;
    while (left > 0 || depth > 1) begin
      if (depth >= 2 && (left == 0 || $urandom_range(0, 1) == 1)) begin
        syms.push_back(random_operator());
        depth--;
      end else begin
        syms.push_back(random_operand());
        depth++;
        left--;
      end
    end
  endtask

  // Out-channel back-pressure in short random bursts.
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run != 0) begin
      out_stall <= 1'b1;
      stall_run <= stall_run - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_run <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%0d status=%0d",
                                  out_data.result_value, out_data.status));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        status_seen[out_data.status]++;
        if (out_data.result_value !== want.result_value)
          report_mismatch($sformatf("result_value got %0d expected %0d",
                                    out_data.result_value, want.result_value));
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status got %0d expected %0d",
                                    out_data.status, want.status));
      end
    end
  end

  initial begin
    plan_row_t  directed_plan [$];
    logic [7:0] syms [$];
    int         pick, idx;

    directed_plan = '{
      plan_step(digit(9), 1'b1, 1'b1, 9, ST_OK),
      plan_step(SYM_ADD,  1'b1, 1'b1, 0, ST_UNDER),
      plan_step(8'hFF,    1'b1, 1'b1, 207, ST_OK),
      plan_step(8'h00,    1'b1, 1'b1, -48, ST_OK),
      plan_step(digit(7), 1'b0, 1'b0, 0, ST_OK),
      plan_step(digit(3), 1'b0, 1'b0, 0, ST_OK),
      plan_step(SYM_SUB,  1'b1, 1'b0, 0, ST_OK),
      plan_step(digit(6), 1'b0, 1'b0, 0, ST_OK),
      plan_step(digit(7), 1'b0, 1'b0, 0, ST_OK),
      plan_step(SYM_MUL,  1'b1, 1'b0, 0, ST_OK),
      plan_step(digit(9), 1'b0, 1'b0, 0, ST_OK),
      plan_step(digit(0), 1'b0, 1'b0, 0, ST_OK),
      plan_step(SYM_DIV,  1'b1, 1'b1, 0, ST_DIVZ),
      plan_step(SYM_ADD,  1'b0, 1'b0, 0, ST_OK),
      plan_step(digit(5), 1'b1, 1'b1, 0, ST_UNDER),
      plan_step(digit(1), 1'b0, 1'b0, 0, ST_OK),
      plan_step(digit(2), 1'b1, 1'b0, 0, ST_OK),
      plan_step(digit(0), 1'b0, 1'b0, 0, ST_OK),
      plan_step(digit(7), 1'b0, 1'b0, 0, ST_OK),
      plan_step(SYM_SUB,  1'b0, 1'b0, 0, ST_OK),
      plan_step(digit(2), 1'b0, 1'b0, 0, ST_OK),
      plan_step(SYM_DIV,  1'b1, 1'b0, 0, ST_OK)
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_plan[i])
      feed_symbol(directed_plan[i].item, directed_plan[i].typed, directed_plan[i].want);
    drain_results();

    while (live_items < ITEM_TARGET) begin
      if (live_items >= ITEM_TARGET - CALM_TAIL) calm <= 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        build_well_formed(syms);
      end else if (pick < 78) begin
        // Too many operands: the block must flag overflow and ignore the rest.
        syms = {};
        repeat ($urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 4))
          syms.push_back(random_operand());
        if ($urandom_range(0, 1) == 1) syms.push_back(random_operator());
      end else if (pick < 82) begin
        // Builds the most negative value from 128^4 * 8, then divides it by -1.
        syms = '{digit(128), digit(128), SYM_MUL, digit(128), SYM_MUL, digit(128),
                 SYM_MUL, digit(8), SYM_MUL, digit(0), digit(1), SYM_SUB, SYM_DIV};
      end else if (pick < 90) begin
        build_well_formed(syms);
        idx = $urandom_range(0, syms.size() - 1);
        case ($urandom_range(0, 2))
          0:       syms.delete(idx);
          1:       syms.insert(idx, random_operator());
          default: syms.push_back(random_operand());
        endcase
        if (syms.size() == 0) syms.push_back(random_operand());
      end else begin
        syms = {};
        repeat ($urandom_range(1, 10)) syms.push_back(8'($urandom_range(0, 255)));
      end
      feed_expression(syms);
      if (expressions == 150) drain_results();
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    $display("Evaluated %0d expressions (%0d live characters), %0d results checked",
             expressions, live_items, results_checked);
    $display("Status mix: ok %0d, underflow %0d, overflow %0d, divide by zero %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/pfe_pkg.sv
src/pfe_divider.sv
src/pfe_dpath.sv
src/pfe_ctrl.sv
src/postfix_expression_evaluator.sv
tb/tb_postfix_expression_evaluator.sv
